FILE: hw/rtl/ictf_pkg.sv
// ----------------------------------------------------------------------------
// ictf_pkg
// Shared types, constants and the arctangent table of the complementary tilt filter.
// ----------------------------------------------------------------------------
package ictf_pkg;

    localparam int DIV_W        = 36;   // divider dividend / quotient width
    localparam int DVS_W        = 18;   // divider divisor width
    localparam int SQ_IN_W      = 48;   // square root radicand width
    localparam int ROOT_W       = 24;   // square root result width
    localparam int CX_W         = 28;   // CORDIC x/y width
    localparam int CZ_W         = 24;   // CORDIC angle width
    localparam int CORDIC_STEPS = 16;

    // floor(m / 15625) = (m * INC_RECIP) >> 42 for m < 2^28
    localparam logic [28:0]      INC_RECIP   = 29'd281474977;
    localparam logic [31:0]      INC_HALF    = 32'd125000;
    localparam logic [19:0]      ACC_SCALE   = 20'd1000000;
    localparam logic signed [15:0] RIGHT_ANGLE = 16'sd5760;

    localparam logic [1:0] REG_BLEND_ALPHA = 2'd0;
    localparam logic [1:0] REG_TAP_THRESH  = 2'd1;
    localparam logic [1:0] REG_TAP_HOLDOFF = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQA,
        ST_SQB,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_CORD_GO,
        ST_CORD_WAIT,
        ST_REF,
        ST_GMUL,
        ST_GINC,
        ST_GSUM,
        ST_BMUL,
        ST_BSUM,
        ST_AMUL,
        ST_ADIV_GO,
        ST_ADIV_WAIT,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       sq_a;
        logic       sq_b;
        logic       sqrt_go;
        logic       cord_go;
        logic       ref_ld;
        logic       gmul;
        logic       ginc;
        logic       div_go;
        logic       gsum;
        logic       bmul;
        logic       bsum;
        logic       amul;
        logic       acc_ld;
        logic       commit;
        logic       tilt;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic cord_done;
        logic div_done;
    } sts_t;

    // arctangent table, 1/16384 degree
    function automatic logic signed [CZ_W-1:0] atan_lut(input logic [3:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            4'd0:    v = 24'sd737280;
            4'd1:    v = 24'sd435242;
            4'd2:    v = 24'sd229970;
            4'd3:    v = 24'sd116736;
            4'd4:    v = 24'sd58595;
            4'd5:    v = 24'sd29326;
            4'd6:    v = 24'sd14667;
            4'd7:    v = 24'sd7334;
            4'd8:    v = 24'sd3667;
            4'd9:    v = 24'sd1833;
            4'd10:   v = 24'sd917;
            4'd11:   v = 24'sd458;
            4'd12:   v = 24'sd229;
            4'd13:   v = 24'sd115;
            4'd14:   v = 24'sd57;
            default: v = 24'sd29;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/ictf_div.sv
// ----------------------------------------------------------------------------
// ictf_div
// Serial restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ictf_div
    import ictf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;

    always_comb
    begin
        trial = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = trial - {1'b0, dvs_reg};
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/ictf_isqrt.sv
// ----------------------------------------------------------------------------
// ictf_isqrt
// Serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ictf_isqrt
    import ictf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SQ_IN_W-1:0] radicand,
    output logic               done,
    output logic [ROOT_W-1:0]  root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 3;

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SQ_IN_W-1:0] v_reg;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [REM_W-1:0]   shifted;
    logic [REM_W-1:0]   trial;

    always_comb
    begin
        shifted = {rem_reg[REM_W-3:0], v_reg[SQ_IN_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        if (shifted >= trial)
        begin
            rem_next  = shifted - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = shifted;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[SQ_IN_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hw/rtl/ictf_cordic.sv
// ----------------------------------------------------------------------------
// ictf_cordic
// Iterative vectoring CORDIC, one rotation per cycle.
// ----------------------------------------------------------------------------
module ictf_cordic
    import ictf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [ROOT_W-1:0]      x_in,
    input  logic signed [CX_W-1:0] y_in,
    output logic                   done,
    output logic signed [CZ_W-1:0] angle
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic signed [CX_W-1:0] x_reg, x_next;
    logic signed [CX_W-1:0] y_reg, y_next;
    logic signed [CZ_W-1:0] z_reg, z_next;
    logic signed [CX_W-1:0] dx, dy;
    logic signed [CZ_W-1:0] step_angle;

    always_comb
    begin
        dx         = y_reg >>> cnt_reg;
        dy         = x_reg >>> cnt_reg;
        step_angle = atan_lut(4'(cnt_reg));
        if (y_reg > 0)
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + step_angle;
        end
        else
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - step_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= signed'({{(CX_W-ROOT_W){1'b0}}, x_in});
            y_reg <= y_in;
            z_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

FILE: hw/rtl/ictf_datapath.sv
// ----------------------------------------------------------------------------
// ictf_datapath
// Operand registers, arithmetic units, filter state and result registers.
// ----------------------------------------------------------------------------
module ictf_datapath
    import ictf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    output sts_t         sts,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic [127:0] s_axis_tdata,
    output logic [191:0] m_axis_tdata,
    output logic         m_axis_tuser
);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    logic [15:0]        alpha_reg;
    logic [30:0]        thresh_reg;
    logic [31:0]        holdoff_reg;

    logic signed [31:0] last_angle_reg [3];
    logic signed [15:0] last_gyro_reg  [3];
    logic [31:0]        since_reg;

    logic signed [15:0] gyro_reg [3];
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] ref_reg [3];

    logic [31:0]        s_reg;
    logic signed [32:0] p_reg;
    logic [56:0]        inc_prod_reg;
    logic signed [32:0] gyr_reg;
    logic signed [49:0] m1_reg;
    logic signed [33:0] m2_reg;
    logic [DIV_W-1:0]   dmag_reg;
    logic               dneg_reg;
    logic signed [31:0] ang_reg [3];
    logic signed [31:0] acc_reg [3];

    logic [191:0]       out_data_reg;
    logic               out_tap_reg;

    logic               sqrt_done, cord_done, div_done;
    logic [ROOT_W-1:0]  root;
    logic signed [CZ_W-1:0] cz;
    logic [DIV_W-1:0]   quo;

    logic signed [15:0] sq_a_op, num_op;
    logic [31:0]        p_mag;
    logic [31:0]        inc_sum;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic signed [CZ_W-1:0] z_round;
    logic signed [15:0] tilt_val;
    logic signed [32:0] inc_s;
    logic signed [50:0] bsum;
    logic signed [34:0] bshift;
    logic signed [31:0] ang_val;
    logic signed [16:0] diff;
    logic [16:0]        diff_mag;
    logic signed [31:0] acc_val;
    logic [31:0]        mag_y;
    logic [32:0]        since_sum;
    logic [31:0]        since_sat;
    logic               tap;

    assign sq_a_op = cmd.tilt ? ay_reg : ax_reg;
    assign num_op  = cmd.tilt ? ax_reg : ay_reg;

    ictf_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_go),
        .radicand ({s_reg, 16'h0000}),
        .done     (sqrt_done),
        .root     (root)
    );

    ictf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cord_go),
        .x_in  (root),
        .y_in  ({{(CX_W-24){num_op[15]}}, num_op, 8'h00}),
        .done  (cord_done),
        .angle (cz)
    );

    always_comb
    begin
        p_mag   = p_reg[32] ? 32'(-p_reg) : p_reg[31:0];
        inc_sum = p_mag + INC_HALF;
    end

    assign div_dividend = dmag_reg;
    assign div_divisor  = {{(DVS_W-16){1'b0}}, dt_reg};

    ictf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quo)
    );

    assign sts.sqrt_done = sqrt_done;
    assign sts.cord_done = cord_done;
    assign sts.div_done  = div_done;

    always_comb
    begin
        z_round = (cz + CZ_W'(128)) >>> 8;
        if (root == '0)
        begin
            if (num_op > 0)
                tilt_val = RIGHT_ANGLE;
            else if (num_op < 0)
                tilt_val = -RIGHT_ANGLE;
            else
                tilt_val = '0;
        end
        else
        begin
            tilt_val = z_round[15:0];
        end

        // rounded increment: (|p| + 125000) / 16 / 15625
        inc_s = p_reg[32] ? -signed'({18'h0, inc_prod_reg[56:42]})
                          : signed'({18'h0, inc_prod_reg[56:42]});

        bsum   = 51'(m1_reg) + 51'(m2_reg) + 51'sd32768;
        bshift = 35'(bsum >>> 16);
        if (bshift > 35'(S32_MAX))
            ang_val = S32_MAX;
        else if (bshift < 35'(S32_MIN))
            ang_val = S32_MIN;
        else
            ang_val = bshift[31:0];

        diff     = 17'(gyro_reg[cmd.axis]) - 17'(last_gyro_reg[cmd.axis]);
        diff_mag = diff[16] ? 17'(-diff) : diff;

        if (dt_reg == '0)
        begin
            if (dneg_reg)
                acc_val = S32_MIN;
            else if (dmag_reg == '0)
                acc_val = '0;
            else
                acc_val = S32_MAX;
        end
        else if (dneg_reg)
        begin
            if (quo > DIV_W'(33'h080000000))
                acc_val = S32_MIN;
            else
                acc_val = signed'(32'(0) - quo[31:0]);
        end
        else
        begin
            if (quo > DIV_W'(32'h7FFFFFFF))
                acc_val = S32_MAX;
            else
                acc_val = signed'(quo[31:0]);
        end

        mag_y     = acc_reg[1][31] ? 32'(-acc_reg[1]) : acc_reg[1];
        since_sum = {1'b0, since_reg} + {17'h0, dt_reg};
        since_sat = since_sum[32] ? 32'hFFFFFFFF : since_sum[31:0];
        tap       = (mag_y > {1'b0, thresh_reg}) && (since_sat > holdoff_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= 16'd64225;
            thresh_reg  <= 31'd160000;
            holdoff_reg <= 32'd100000;
            since_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                last_angle_reg[i] <= '0;
                last_gyro_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLEND_ALPHA: alpha_reg   <= cfg_wdata[15:0];
                    REG_TAP_THRESH:  thresh_reg  <= cfg_wdata[30:0];
                    REG_TAP_HOLDOFF: holdoff_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.commit)
            begin
                since_reg <= tap ? 32'h0 : since_sat;
                for (int i = 0; i < 3; i++)
                begin
                    last_angle_reg[i] <= ang_reg[i];
                    last_gyro_reg[i]  <= gyro_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            gyro_reg[0] <= s_axis_tdata[15:0];
            gyro_reg[1] <= s_axis_tdata[31:16];
            gyro_reg[2] <= s_axis_tdata[47:32];
            ax_reg      <= s_axis_tdata[63:48];
            ay_reg      <= s_axis_tdata[79:64];
            az_reg      <= s_axis_tdata[95:80];
            ref_reg[2]  <= 16'(signed'(s_axis_tdata[110:96]));
            dt_reg      <= s_axis_tdata[126:111];
        end
        if (cmd.sq_a)
            s_reg <= 32'(sq_a_op * sq_a_op);
        if (cmd.sq_b)
            s_reg <= s_reg + 32'(az_reg * az_reg);
        if (cmd.ref_ld)
            ref_reg[{1'b0, cmd.tilt}] <= tilt_val;
        if (cmd.gmul)
            p_reg <= 33'(gyro_reg[cmd.axis]) * signed'({17'h0, dt_reg});
        if (cmd.ginc)
            inc_prod_reg <= inc_sum[31:4] * INC_RECIP;
        if (cmd.gsum)
            gyr_reg <= 33'(last_angle_reg[cmd.axis]) + inc_s;
        if (cmd.bmul)
        begin
            m1_reg <= signed'({1'b0, alpha_reg}) * gyr_reg;
            m2_reg <= signed'({1'b0, 17'(18'h10000 - {2'b00, alpha_reg})})
                      * ref_reg[cmd.axis];
        end
        if (cmd.bsum)
            ang_reg[cmd.axis] <= ang_val;
        if (cmd.amul)
        begin
            dneg_reg <= diff[16];
            dmag_reg <= DIV_W'(diff_mag * ACC_SCALE);
        end
        if (cmd.acc_ld)
            acc_reg[cmd.axis] <= acc_val;
        if (cmd.commit)
        begin
            out_data_reg <= {acc_reg[2], acc_reg[1], acc_reg[0],
                             ang_reg[2], ang_reg[1], ang_reg[0]};
            out_tap_reg  <= tap;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_tap_reg;

endmodule

FILE: hw/rtl/ictf_ctrl.sv
// ----------------------------------------------------------------------------
// ictf_ctrl
// Sequencer: steps the datapath through tilt, blend and rate phases.
// ----------------------------------------------------------------------------
module ictf_ctrl
    import ictf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [1:0] axis_reg;
    logic       tilt_reg;
    logic       out_valid_reg;
    logic       slot_free;

    assign slot_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_axis_tvalid) state_next = ST_SQA;
            ST_SQA:       state_next = ST_SQB;
            ST_SQB:       state_next = ST_SQRT_GO;
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (sts.sqrt_done) state_next = ST_CORD_GO;
            ST_CORD_GO:   state_next = ST_CORD_WAIT;
            ST_CORD_WAIT: if (sts.cord_done) state_next = ST_REF;
            ST_REF:       state_next = tilt_reg ? ST_GMUL : ST_SQA;
            ST_GMUL:      state_next = ST_GINC;
            ST_GINC:      state_next = ST_GSUM;
            ST_GSUM:      state_next = ST_BMUL;
            ST_BMUL:      state_next = ST_BSUM;
            ST_BSUM:      state_next = ST_AMUL;
            ST_AMUL:      state_next = ST_ADIV_GO;
            ST_ADIV_GO:   state_next = ST_ADIV_WAIT;
            ST_ADIV_WAIT: if (sts.div_done) state_next = ST_ACC;
            ST_ACC:       state_next = (axis_reg == 2'd2) ? ST_OUT : ST_GMUL;
            ST_OUT:       if (slot_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.tilt    = tilt_reg;
        cmd.axis    = axis_reg;
        unique case (state_reg)
            ST_IDLE:      cmd.capture = s_axis_tvalid;
            ST_SQA:       cmd.sq_a    = 1'b1;
            ST_SQB:       cmd.sq_b    = 1'b1;
            ST_SQRT_GO:   cmd.sqrt_go = 1'b1;
            ST_CORD_GO:   cmd.cord_go = 1'b1;
            ST_REF:       cmd.ref_ld  = 1'b1;
            ST_GMUL:      cmd.gmul    = 1'b1;
            ST_GINC:      cmd.ginc    = 1'b1;
            ST_GSUM:      cmd.gsum    = 1'b1;
            ST_BMUL:      cmd.bmul    = 1'b1;
            ST_BSUM:      cmd.bsum    = 1'b1;
            ST_AMUL:      cmd.amul    = 1'b1;
            ST_ADIV_GO:   cmd.div_go  = 1'b1;
            ST_ACC:       cmd.acc_ld  = 1'b1;
            ST_OUT:       cmd.commit  = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            tilt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                axis_reg <= '0;
                tilt_reg <= 1'b0;
            end
            else if (state_reg == ST_REF)
                tilt_reg <= 1'b1;
            else if (state_reg == ST_ACC)
                axis_reg <= axis_reg + 1'b1;

            if (state_reg == ST_OUT && slot_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

endmodule

FILE: hw/rtl/imu_complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary roll/pitch/yaw filter with angular rate derivative and tap
// flag, one result per inertial sample.
// ----------------------------------------------------------------------------
// channel  dir  data                              user
// s_axis   in   tdata 128b: sample fields         -
// m_axis   out  tdata 192b: angles, ang accel     tap_hit
// cfg      in   cfg_we / cfg_index / cfg_wdata    -
//
// Each sample runs through two square roots, two CORDIC passes and three serial
// divisions by the sample time before its result is committed; another sample
// is accepted only after that commit.
// A new sample is taken only in idle; a finished result waits in the output
// register and a stalled output holds the sequencer before it commits.
// Reset clears filter state and loads register defaults.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter
    import ictf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, mag_heading,
    // sample_time_us, pad
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // angle_x, angle_y, angle_z, ang_accel_x, ang_accel_y, ang_accel_z
    output logic [191:0] m_axis_tdata,
    // tap_hit
    output logic         m_axis_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    ictf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    ictf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule
